// File: hdl/pa_pkg.sv
// Primitive assembler package: mode codes, register indexes, queue sizing
// and the primitive record passed from the front end to the back end.
// No dependencies.
package pa_pkg;

   localparam int INDEX_BITS = 32;
   localparam int VERT_W     = 32;
   localparam logic [VERT_W-1:0] IDX_MASK =
      VERT_W'((64'd1 << INDEX_BITS) - 64'd1);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIM_MODE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_LIMIT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      MODE_TRI_LIST   = 3'd0,
      MODE_TRI_STRIP  = 3'd1,
      MODE_TRI_FAN    = 3'd2,
      MODE_LINE_LIST  = 3'd3,
      MODE_LINE_STRIP = 3'd4
   } mode_type;

   typedef struct packed {
      logic [VERT_W-1:0] vert_a;
      logic [VERT_W-1:0] vert_b;
      logic [VERT_W-1:0] vert_c;
      logic              is_line;
      logic [31:0]       prim_number;
      logic              last_prim;
   } prim_type;

endpackage

// File: hdl/pa_channels.sv
// Valid/ready channel interfaces for the primitive assembler: the index
// request channel and the primitive response channel. Depends on pa_pkg.
interface pa_req_if;
   logic                      valid;
   logic                      ready;
   logic [pa_pkg::VERT_W-1:0] vertex_index;
   logic                      end_of_stream;

   modport source (output valid, output vertex_index, output end_of_stream,
                   input ready);
   modport sink   (input valid, input vertex_index, input end_of_stream,
                   output ready);
endinterface

interface pa_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [pa_pkg::VERT_W-1:0] vert_a;
   logic [pa_pkg::VERT_W-1:0] vert_b;
   logic [pa_pkg::VERT_W-1:0] vert_c;
   logic                      is_line;
   logic [31:0]               prim_number;
   logic                      out_of_range;
   logic                      last_prim;

   modport source (output valid, output vert_a, output vert_b, output vert_c,
                   output is_line, output prim_number, output out_of_range,
                   output last_prim, input ready);
   modport sink   (input valid, input vert_a, input vert_b, input vert_c,
                   input is_line, input prim_number, input out_of_range,
                   input last_prim, output ready);
endinterface

// File: hdl/primitive_assembler_unit.sv
// Primitive assembler top level: configuration registers, front end,
// primitive queue and back end. Depends on pa_pkg, pa_channels, pa_front,
// pa_queue and pa_back.
//
// req_chan carries one vertex index per transaction plus an end-of-stream
// flag marking the last index of a draw. rsp_chan carries one assembled
// primitive (three indices, line flag, running number within the draw,
// out-of-range flag, last flag) per transaction. An index that does not
// complete a primitive produces no response.
// Mode and vertex limit are written through the csr_ port, index 0 and 1;
// the user must write them only while the block is idle; it is not enforced.
// Throughput: one index per cycle while the queue is not full. The front
// end updates the held indices in the accept cycle and pushes into a
// four-entry queue at the accepting edge; the back end then loads its
// output register from the queue whenever that register is empty or being
// taken. rsp_chan.valid comes straight from the output register.
// When the receiver stalls, the output register holds and the queue fills;
// req_chan.ready drops only once the queue is full.
// Reset (synchronous) clears the held indices, primitive counter and
// queue, sets triangle list mode and the vertex limit to all ones.
module primitive_assembler_unit (
   input  logic                          clock,
   input  logic                          reset,
   pa_req_if.sink                        req_chan,
   pa_rsp_if.source                      rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [pa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pa_pkg::CSR_DATA_W-1:0] csr_wdata
);

   pa_pkg::mode_type          mode_ff;
   logic [pa_pkg::VERT_W-1:0] limit_ff;
   logic                      push;
   pa_pkg::prim_type          push_data;
   logic                      pop;
   pa_pkg::prim_type          pop_data;
   logic                      queue_full;
   logic                      queue_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= pa_pkg::MODE_TRI_LIST;
         limit_ff <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            pa_pkg::CSR_PRIM_MODE:    mode_ff  <= pa_pkg::mode_type'(csr_wdata[2:0]);
            pa_pkg::CSR_VERTEX_LIMIT: limit_ff <= csr_wdata[pa_pkg::VERT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   pa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .prim_mode  (mode_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   pa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   pa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .vertex_limit (limit_ff),
      .queue_empty  (queue_empty),
      .queue_data   (pop_data),
      .pop          (pop),
      .rsp          (rsp_chan)
   );

endmodule

// File: hdl/pa_front.sv
// Assembly front end: accepts vertex indices, keeps the held indices and
// primitive counter, and pushes completed primitives into the queue.
// Depends on pa_pkg and pa_req_if.
module pa_front (
   input  logic                 clock,
   input  logic                 reset,
   pa_req_if.sink               req,
   input  pa_pkg::mode_type     prim_mode,
   input  logic                 queue_full,
   output logic                 push,
   output pa_pkg::prim_type     push_data
);

   logic [pa_pkg::VERT_W-1:0] first_ff, first_in;
   logic [pa_pkg::VERT_W-1:0] second_ff, second_in;
   logic [pa_pkg::VERT_W-1:0] third_ff, third_in;
   logic [1:0]                fill_ff, fill_in;
   logic [31:0]               count_ff, count_in;
   logic                      accept;
   logic                      emit;
   logic                      emit_line;
   logic [pa_pkg::VERT_W-1:0] v;

   assign req.ready = !queue_full;
   assign accept    = req.valid && !queue_full;
   assign v         = req.vertex_index & pa_pkg::IDX_MASK;

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      third_in  = third_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      emit_line = 1'b0;
      if (accept) begin
         unique case (prim_mode)
            pa_pkg::MODE_TRI_LIST: begin
               if (fill_ff == 2'd1) begin
                  second_in = v;
                  fill_in   = 2'd2;
               end else if (fill_ff == 2'd2) begin
                  third_in = v;
                  fill_in  = 2'd0;
                  emit     = 1'b1;
               end else begin
                  first_in = v;
                  fill_in  = 2'd1;
               end
            end
            pa_pkg::MODE_TRI_STRIP, pa_pkg::MODE_TRI_FAN: begin
               if (fill_ff == 2'd0) begin
                  first_in = v;
                  fill_in  = 2'd1;
               end else if (fill_ff == 2'd1) begin
                  second_in = v;
                  fill_in   = 2'd2;
               end else begin
                  // strip winding: odd primitives drop the first index
                  if (fill_ff == 2'd3) begin
                     if (prim_mode == pa_pkg::MODE_TRI_STRIP && count_ff[0])
                        first_in = third_ff;
                     else
                        second_in = third_ff;
                  end
                  third_in = v;
                  fill_in  = 2'd3;
                  emit     = 1'b1;
               end
            end
            pa_pkg::MODE_LINE_LIST: begin
               if (fill_ff == 2'd1) begin
                  second_in = v;
                  fill_in   = 2'd0;
                  emit      = 1'b1;
                  emit_line = 1'b1;
               end else begin
                  first_in = v;
                  fill_in  = 2'd1;
               end
            end
            pa_pkg::MODE_LINE_STRIP: begin
               if (fill_ff == 2'd0) begin
                  first_in = v;
                  fill_in  = 2'd1;
               end else begin
                  if (fill_ff != 2'd1)
                     first_in = second_ff;
                  second_in = v;
                  fill_in   = 2'd2;
                  emit      = 1'b1;
                  emit_line = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (emit)
            count_in = count_ff + 32'd1;
         if (req.end_of_stream) begin
            first_in  = '0;
            second_in = '0;
            third_in  = '0;
            fill_in   = 2'd0;
            count_in  = '0;
         end
      end
   end

   always_comb begin
      push                  = emit;
      push_data.vert_a      = first_in;
      push_data.vert_b      = second_in;
      push_data.vert_c      = emit_line ? '0 : third_in;
      push_data.is_line     = emit_line;
      push_data.prim_number = count_ff;
      push_data.last_prim   = req.end_of_stream;
      // end of stream clears the held state, so take the values before clearing
      if (req.end_of_stream) begin
         push_data.vert_a = first_ff;
         push_data.vert_b = second_ff;
         push_data.vert_c = '0;
         unique case (prim_mode)
            pa_pkg::MODE_TRI_LIST: begin
               push_data.vert_c = v;
            end
            pa_pkg::MODE_TRI_STRIP, pa_pkg::MODE_TRI_FAN: begin
               push_data.vert_c = v;
               if (fill_ff == 2'd3) begin
                  if (prim_mode == pa_pkg::MODE_TRI_STRIP && count_ff[0])
                     push_data.vert_a = third_ff;
                  else
                     push_data.vert_b = third_ff;
               end
            end
            pa_pkg::MODE_LINE_LIST: begin
               push_data.vert_b = v;
            end
            pa_pkg::MODE_LINE_STRIP: begin
               if (fill_ff != 2'd1)
                  push_data.vert_a = second_ff;
               push_data.vert_b = v;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
         third_ff  <= '0;
         fill_ff   <= 2'd0;
         count_ff  <= '0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         fill_ff   <= fill_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/pa_queue.sv
// Small FIFO of assembled primitives between front end and back end.
// Depends on pa_pkg.
module pa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pa_pkg::prim_type push_data,
   input  logic             pop,
   output pa_pkg::prim_type pop_data,
   output logic             full,
   output logic             empty
);

   pa_pkg::prim_type                entry_ff [pa_pkg::QUEUE_DEPTH];
   logic [pa_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [pa_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [pa_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign full     = (count_ff == pa_pkg::QUEUE_CNT_W'(pa_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/pa_back.sv
// Back end: pops primitives from the queue, checks indices against the
// vertex limit and holds the result in the output register.
// Depends on pa_pkg and pa_rsp_if.
module pa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [pa_pkg::VERT_W-1:0] vertex_limit,
   input  logic                      queue_empty,
   input  pa_pkg::prim_type          queue_data,
   output logic                      pop,
   pa_rsp_if.source                  rsp
);

   logic             valid_ff, valid_in;
   pa_pkg::prim_type prim_ff;
   logic             oor_ff, oor_in;
   logic             load;

   assign load = !queue_empty && (!valid_ff || rsp.ready);
   assign pop  = load;

   always_comb begin
      oor_in = (queue_data.vert_a >= vertex_limit) ||
               (queue_data.vert_b >= vertex_limit) ||
               (!queue_data.is_line && queue_data.vert_c >= vertex_limit);
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (rsp.ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prim_ff <= queue_data;
         oor_ff  <= oor_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.vert_a       = prim_ff.vert_a;
   assign rsp.vert_b       = prim_ff.vert_b;
   assign rsp.vert_c       = prim_ff.vert_c;
   assign rsp.is_line      = prim_ff.is_line;
   assign rsp.prim_number  = prim_ff.prim_number;
   assign rsp.out_of_range = oor_ff;
   assign rsp.last_prim    = prim_ff.last_prim;

endmodule

// File: test/tb_primitive_assembler_unit.sv
// Self-checking testbench for primitive_assembler_unit: directed draws per
// assembly mode, then random draws checked against an in-bench assembler.
// Depends on pa_pkg, pa_channels and the RTL of primitive_assembler_unit.
module tb_primitive_assembler_unit;

   // mode codes the block ignores
   localparam logic [2:0] MODE_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] MODE_RESERVED_LAST  = 3'd7;

   typedef struct {
      logic [31:0] vert_a;
      logic [31:0] vert_b;
      logic [31:0] vert_c;
      logic        is_line;
      logic [31:0] prim_number;
      logic        out_of_range;
      logic        last_prim;
   } prim_result_type;

   logic                          clock;
   logic                          reset;
   logic                          csr_wr_en;
   logic [pa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pa_pkg::CSR_DATA_W-1:0] csr_wdata;

   pa_req_if req_chan ();
   pa_rsp_if rsp_chan ();

   primitive_assembler_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // assembler state mirrored in the bench
   logic [2:0]  asm_mode   = pa_pkg::MODE_TRI_LIST;
   logic [31:0] vert_limit = 32'hFFFF_FFFF;
   logic [31:0] held_a     = '0;
   logic [31:0] held_b     = '0;
   logic [31:0] held_c     = '0;
   logic [1:0]  fill_level = '0;
   logic [31:0] prim_count = '0;

   prim_result_type pending_prims[$];
   int              error_count = 0;
   int              sent_count  = 0;
   bit              send_gaps   = 1'b1;
   bit              recv_stalls = 1'b1;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void emit_prim(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] c, input logic line,
                                     input logic last);
      prim_result_type p;
      p.vert_a       = a;
      p.vert_b       = b;
      p.vert_c       = line ? 32'd0 : c;
      p.is_line      = line;
      p.prim_number  = prim_count;
      p.out_of_range = (a >= vert_limit) || (b >= vert_limit) ||
                       (!line && c >= vert_limit);
      p.last_prim    = last;
      pending_prims.insert(pending_prims.size(), p);
      prim_count = prim_count + 32'd1;
   endfunction

   function automatic void assemble_index(input logic [31:0] raw, input logic eos);
      logic [31:0] v;
      v = raw & pa_pkg::IDX_MASK;
      case (asm_mode)
         pa_pkg::MODE_TRI_LIST: begin
            if (fill_level == 2'd1) begin
               held_b = v;
               fill_level = 2'd2;
            end else if (fill_level == 2'd2) begin
               held_c = v;
               fill_level = 2'd0;
               emit_prim(held_a, held_b, held_c, 1'b0, eos);
            end else begin
               held_a = v;
               fill_level = 2'd1;
            end
         end
         pa_pkg::MODE_TRI_STRIP, pa_pkg::MODE_TRI_FAN: begin
            if (fill_level == 2'd0) begin
               held_a = v;
               fill_level = 2'd1;
            end else if (fill_level == 2'd1) begin
               held_b = v;
               fill_level = 2'd2;
            end else begin
               // strip alternates which held index is replaced to keep winding
               if (fill_level == 2'd3) begin
                  if (asm_mode == pa_pkg::MODE_TRI_STRIP && prim_count[0])
                     held_a = held_c;
                  else
                     held_b = held_c;
               end
               held_c = v;
               fill_level = 2'd3;
               emit_prim(held_a, held_b, held_c, 1'b0, eos);
            end
         end
         pa_pkg::MODE_LINE_LIST: begin
            if (fill_level == 2'd1) begin
               held_b = v;
               fill_level = 2'd0;
               emit_prim(held_a, held_b, 32'd0, 1'b1, eos);
            end else begin
               held_a = v;
               fill_level = 2'd1;
            end
         end
         pa_pkg::MODE_LINE_STRIP: begin
            if (fill_level == 2'd0) begin
               held_a = v;
               fill_level = 2'd1;
            end else begin
               if (fill_level != 2'd1)
                  held_a = held_b;
               held_b = v;
               fill_level = 2'd2;
               emit_prim(held_a, held_b, 32'd0, 1'b1, eos);
            end
         end
         default: ;
      endcase
      if (eos) begin
         held_a     = '0;
         held_b     = '0;
         held_c     = '0;
         fill_level = '0;
         prim_count = '0;
      end
   endfunction

   function automatic int field_mismatch(input string name, input logic [31:0] exp_val,
                                         input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   // input monitor: every accepted index goes through the bench assembler
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         assemble_index(req_chan.vertex_index, req_chan.end_of_stream);
   end

   // response side: random stalls and per-transaction checking
   always @(posedge clock) begin
      prim_result_type exp_prim;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_prims.size() == 0) begin
            $error("primitive with no expectation: a=%0h b=%0h c=%0h num=%0h",
                   rsp_chan.vert_a, rsp_chan.vert_b, rsp_chan.vert_c,
                   rsp_chan.prim_number);
            error_count++;
         end else begin
            exp_prim = pending_prims.pop_front();
            error_count += field_mismatch("vert_a", exp_prim.vert_a, rsp_chan.vert_a);
            error_count += field_mismatch("vert_b", exp_prim.vert_b, rsp_chan.vert_b);
            error_count += field_mismatch("vert_c", exp_prim.vert_c, rsp_chan.vert_c);
            error_count += field_mismatch("is_line", 32'(exp_prim.is_line),
                                          32'(rsp_chan.is_line));
            error_count += field_mismatch("prim_number", exp_prim.prim_number,
                                          rsp_chan.prim_number);
            error_count += field_mismatch("out_of_range", 32'(exp_prim.out_of_range),
                                          32'(rsp_chan.out_of_range));
            error_count += field_mismatch("last_prim", 32'(exp_prim.last_prim),
                                          32'(rsp_chan.last_prim));
         end
      end
      rsp_chan.ready <= !(recv_stalls && $urandom_range(99) < 12);
   end

   // called right after the clock rises; returns when the index is accepted
   task automatic send_index(input logic [31:0] idx, input logic eos);
      while (send_gaps && $urandom_range(99) < 12) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.vertex_index  <= idx;
      req_chan.end_of_stream <= eos;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sent_count++;
   endtask

   // stop sending and wait for every outstanding primitive, plus slack for
   // indices that are still in flight but produce nothing
   task automatic drain_prims();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_prims.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [pa_pkg::CSR_IDX_W-1:0] index,
                            input logic [31:0] data);
      drain_prims();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == pa_pkg::CSR_PRIM_MODE)
         asm_mode = data[2:0];
      else
         vert_limit = data;
   endtask

   function automatic logic [31:0] pick_index();
      case ($urandom_range(4))
         0:       return $urandom;
         1:       return $urandom_range(40);
         2:       return vert_limit + 32'($urandom_range(2)) - 32'd1;
         3:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
         default: return $urandom_range(300);
      endcase
   endfunction

   task automatic test_triangle_list();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_TRI_LIST));
      write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'hFFFF_FFFF);
      send_index(32'd0, 1'b0);
      send_index(32'hFFFF_FFFF, 1'b0);
      send_index(32'd5, 1'b0);
      // partial triangle at end of draw is dropped
      send_index(32'd9, 1'b0);
      send_index(32'd10, 1'b1);
   endtask

   task automatic test_triangle_strip();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_TRI_STRIP));
      write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'd6);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b0);
      send_index(32'd6, 1'b0);
      send_index(32'd4, 1'b1);
   endtask

   task automatic test_triangle_fan();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_TRI_FAN));
      write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'd0);
      send_index(32'd0, 1'b0);
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b1);
   endtask

   task automatic test_line_list();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_LINE_LIST));
      write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'hFFFF_FFFF);
      send_index(32'hFFFF_FFFF, 1'b0);
      send_index(32'd0, 1'b0);
      send_index(32'd5, 1'b1);
   endtask

   task automatic test_line_strip();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_LINE_STRIP));
      write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'd8);
      send_index(32'd7, 1'b0);
      send_index(32'd8, 1'b0);
      send_index(32'd9, 1'b1);
   endtask

   // reserved mode ignores indices, but its end flag still clears held state
   task automatic test_reserved_mode();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_LINE_LIST));
      send_index(32'd4, 1'b0);
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(MODE_RESERVED_LAST));
      send_index(32'd12, 1'b1);
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_LINE_LIST));
      send_index(32'd20, 1'b0);
      send_index(32'd21, 1'b1);
   endtask

   // held indices carry over when the mode changes inside a draw
   task automatic test_mode_switch();
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_LINE_STRIP));
      send_index(32'd1, 1'b0);
      send_index(32'd2, 1'b0);
      send_index(32'd3, 1'b0);
      write_csr(pa_pkg::CSR_PRIM_MODE, 32'(pa_pkg::MODE_TRI_LIST));
      send_index(32'd4, 1'b1);
   endtask

   task automatic test_random_draws(input int items, input bit with_idling);
      logic [2:0] mode;
      int         len;
      int         stop_at;
      bit         runs_on;
      send_gaps   = with_idling;
      recv_stalls = with_idling;
      stop_at     = sent_count + items;
      while (sent_count < stop_at) begin
         if ($urandom_range(3) == 0) begin
            mode = ($urandom_range(9) == 0) ?
                   3'($urandom_range(MODE_RESERVED_FIRST, MODE_RESERVED_LAST)) :
                   3'($urandom_range(pa_pkg::MODE_TRI_LIST, pa_pkg::MODE_LINE_STRIP));
            write_csr(pa_pkg::CSR_PRIM_MODE, 32'(mode));
         end
         if ($urandom_range(4) == 0) begin
            case ($urandom_range(4))
               0, 1:    write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'($urandom_range(1, 40)));
               2:       write_csr(pa_pkg::CSR_VERTEX_LIMIT, $urandom);
               3:       write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'hFFFF_FFFF);
               default: write_csr(pa_pkg::CSR_VERTEX_LIMIT, 32'd0);
            endcase
         end
         len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         // some draws lack their end flag and run into the next one
         runs_on = ($urandom_range(9) == 0);
         for (int i = 0; i < len; i++)
            send_index(pick_index(), !runs_on && i == len - 1);
         if ($urandom_range(15) == 0)
            drain_prims();
      end
   endtask

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.vertex_index  <= '0;
      req_chan.end_of_stream <= 1'b0;
      csr_wr_en              <= 1'b0;
      csr_index              <= '0;
      csr_wdata              <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_triangle_list();
      test_triangle_strip();
      test_triangle_fan();
      test_line_list();
      test_line_strip();
      test_reserved_mode();
      test_mode_switch();
      test_random_draws(330, 1'b1);
      test_random_draws(100, 1'b0);

      drain_prims();
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("[primitive_assembler_unit] OK");
      else
         $display("[primitive_assembler_unit] ERROR");
      $finish;
   end

   initial begin
      #800000;
      $display("[primitive_assembler_unit] ERROR");
      $finish;
   end

endmodule

// File: sim.f
hdl/pa_pkg.sv
hdl/pa_channels.sv
hdl/pa_front.sv
hdl/pa_queue.sv
hdl/pa_back.sv
hdl/primitive_assembler_unit.sv
test/tb_primitive_assembler_unit.sv
